>>> rtl/core/bba_pkg.sv
// Package for the first-fit bitmap block allocator: constants, types and helpers.
`default_nettype none
package bba_pkg;

  localparam int WORD_BITS  = 64;
  localparam int POS_W      = 6;
  localparam int INDEX_W    = 10;
  localparam int DEF_WORDS  = 16;
  localparam int ADDR_WORDS = 16;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_FAIL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_FIN
  } state_t;

  // position of first set bit counting from the MSB (0 = MSB)
  function automatic logic [POS_W-1:0] first_set_pos(input logic [WORD_BITS-1:0] w);
    logic [POS_W-1:0] p;
    p = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (w[i]) begin
        p = POS_W'(WORD_BITS - 1 - i);
      end
    end
    return p;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/bitmap_block_allocator.sv
// First-fit bitmap block allocator: free map memory, word scan sequencer, output register.
// Allocate: words are scanned from word 0 up to word min(WORDS,16) - 1; a scan that finds no
//   free bit fails. Free: read, then write the word; an index beyond the map goes straight to the result.
// One item in flight; the next beat can be taken once the result is loaded into the output register.
// The scan rate is set by the single map read port feeding one 64-bit priority encoder.
// Reset: synchronous; per-word valid bits clear at once, so every word reads as all free.
`default_nettype none
module bitmap_block_allocator #(
  parameter int WORDS = bba_pkg::DEF_WORDS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        opcode,
  input  wire logic [bba_pkg::INDEX_W-1:0] block_index,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [bba_pkg::INDEX_W-1:0]      granted_index,
  output logic                             status
);

  localparam int WW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int SCAN_WORDS = (WORDS < bba_pkg::ADDR_WORDS) ? WORDS : bba_pkg::ADDR_WORDS;
  localparam logic [WW-1:0] LAST_SCAN = WW'(SCAN_WORDS - 1);
  localparam int PW = bba_pkg::POS_W;
  localparam int IW = bba_pkg::INDEX_W;
  localparam int BW = bba_pkg::WORD_BITS;

  bba_pkg::state_t state, state_next;

  logic [WW-1:0]    ptr, ptr_next;
  logic [WW-1:0]    chk;
  logic             pend, pend_next;
  logic             op_r;
  logic [IW-1:0]    idx_r;
  logic [IW-1:0]    res_index, res_index_next;
  logic             res_status, res_status_next;
  logic             load_out;

  logic [BW-1:0]    mem [WORDS];
  logic [WORDS-1:0] vld;
  logic [BW-1:0]    rd_data;
  logic             rd_vld;
  logic [BW-1:0]    eff;
  logic             wr_en;
  logic [BW-1:0]    wr_data;
  logic [BW-1:0]    mask;
  logic [PW-1:0]    scan_pos;
  logic [PW-1:0]    pos_sel;
  logic [IW-PW-1:0] free_word;
  logic             free_in_range;

  assign in_ready      = (state == bba_pkg::ST_IDLE);
  assign eff           = rd_vld ? rd_data : '1;
  assign scan_pos      = bba_pkg::first_set_pos(eff);
  assign pos_sel       = (op_r == bba_pkg::OP_FREE) ? idx_r[PW-1:0] : scan_pos;
  assign mask          = {1'b1, {(BW-1){1'b0}}} >> pos_sel;
  assign wr_data       = (op_r == bba_pkg::OP_FREE) ? (eff | mask) : (eff & ~mask);
  assign free_word     = block_index[IW-1:PW];
  assign free_in_range = (9'(free_word) < 9'(WORDS));

  // map memory, read every cycle at ptr
  always_ff @(posedge clk) begin
    rd_data <= mem[ptr];
    if (wr_en) begin
      mem[chk] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= vld[ptr];
      if (wr_en) begin
        vld[chk] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bba_pkg::ST_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    chk        <= ptr;
    res_index  <= res_index_next;
    res_status <= res_status_next;
    if (in_valid && in_ready) begin
      op_r  <= opcode;
      idx_r <= block_index;
    end
  end

  always_comb begin
    state_next      = state;
    ptr_next        = ptr;
    pend_next       = 1'b0;
    wr_en           = 1'b0;
    load_out        = 1'b0;
    res_index_next  = res_index;
    res_status_next = res_status;
    unique case (state)
      bba_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (opcode == bba_pkg::OP_ALLOC) begin
            ptr_next   = '0;
            state_next = bba_pkg::ST_SCAN;
          end else if (free_in_range) begin
            ptr_next   = WW'(free_word);
            state_next = bba_pkg::ST_FREE_RD;
          end else begin
            res_index_next  = '0;
            res_status_next = bba_pkg::STAT_OK;
            state_next      = bba_pkg::ST_FIN;
          end
        end
      end
      bba_pkg::ST_SCAN: begin
        pend_next = 1'b1;
        if (ptr != LAST_SCAN) begin
          ptr_next = ptr + WW'(1);
        end
        if (pend) begin
          if (eff != '0) begin
            wr_en           = 1'b1;
            res_index_next  = IW'({chk, scan_pos});
            res_status_next = bba_pkg::STAT_OK;
            state_next      = bba_pkg::ST_FIN;
          end else if (chk == LAST_SCAN) begin
            res_index_next  = '0;
            res_status_next = bba_pkg::STAT_FAIL;
            state_next      = bba_pkg::ST_FIN;
          end
        end
      end
      bba_pkg::ST_FREE_RD: begin
        state_next = bba_pkg::ST_FREE_WR;
      end
      bba_pkg::ST_FREE_WR: begin
        wr_en           = 1'b1;
        res_index_next  = '0;
        res_status_next = bba_pkg::STAT_OK;
        state_next      = bba_pkg::ST_FIN;
      end
      bba_pkg::ST_FIN: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = bba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bba_pkg::ST_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      granted_index <= res_index;
      status        <= res_status;
    end
  end

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == bba_pkg::STAT_FAIL) |-> granted_index == '0)
    else $error("failed allocation carries nonzero index");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready while an item is in flight");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == bba_pkg::ST_SCAN) || (state == bba_pkg::ST_FREE_WR))
    else $error("map write outside scan or free");

  a_fin_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == bba_pkg::ST_FIN)
    else $error("result posted outside finish state");

endmodule
`default_nettype wire

>>> dv/bitmap_block_allocator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_block_allocator: random paced traffic, scoreboard check.
module bitmap_block_allocator_tb;

  localparam int WORDS      = bba_pkg::DEF_WORDS;
  localparam int SCAN_WORDS = (WORDS < bba_pkg::ADDR_WORDS) ? WORDS : bba_pkg::ADDR_WORDS;
  localparam int LIMIT      = 600000;

  typedef struct packed {
    logic [bba_pkg::INDEX_W-1:0] granted;
    logic                        status;
  } alloc_result_t;

  class alloc_scoreboard;
    bit [bba_pkg::WORD_BITS-1:0] free_map [WORDS];
    int unsigned                 taken [$];
    alloc_result_t               expected [$];
    int                          errors;
    int                          alloc_fails;

    function new();
      foreach (free_map[i]) free_map[i] = '1;
      errors = 0;
      alloc_fails = 0;
    endfunction

    function void note_request(logic op, logic [bba_pkg::INDEX_W-1:0] idx);
      alloc_result_t r;
      int w;
      int p;
      bit hit;
      r.granted = '0;
      r.status  = bba_pkg::STAT_OK;
      hit = 1'b0;
      if (op == bba_pkg::OP_ALLOC) begin
        for (w = 0; w < SCAN_WORDS && !hit; w++) begin
          for (p = 0; p < bba_pkg::WORD_BITS && !hit; p++) begin
            if (free_map[w][bba_pkg::WORD_BITS-1-p]) begin
              free_map[w][bba_pkg::WORD_BITS-1-p] = 1'b0;
              r.granted = bba_pkg::INDEX_W'(w * bba_pkg::WORD_BITS + p);
              taken.push_back(w * bba_pkg::WORD_BITS + p);
              hit = 1'b1;
            end
          end
        end
        if (!hit) begin
          r.status = bba_pkg::STAT_FAIL;
          alloc_fails++;
        end
      end else begin
        w = idx / bba_pkg::WORD_BITS;
        p = idx % bba_pkg::WORD_BITS;
        if (w < WORDS) begin
          if (!free_map[w][bba_pkg::WORD_BITS-1-p]) begin
            foreach (taken[i]) begin
              if (taken[i] == idx) begin
                taken.delete(i);
                break;
              end
            end
          end
          free_map[w][bba_pkg::WORD_BITS-1-p] = 1'b1;
        end
      end
      expected.push_back(r);
    endfunction

    function void check_result(logic [bba_pkg::INDEX_W-1:0] g, logic s);
      alloc_result_t e;
      if (expected.size() == 0) begin
        $error("unexpected result beat: granted_index %0d status %0d", g, s);
        errors++;
        return;
      end
      e = expected.pop_front();
      if (g !== e.granted) begin
        $error("granted_index mismatch: expected %0d, got %0d", e.granted, g);
        errors++;
      end
      if (s !== e.status) begin
        $error("status mismatch: expected %0d, got %0d", e.status, s);
        errors++;
      end
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic                        opcode = bba_pkg::OP_ALLOC;
  logic [bba_pkg::INDEX_W-1:0] block_index = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [bba_pkg::INDEX_W-1:0] granted_index;
  logic                        status;

  int unsigned                 cycle_count = 0;
  int                          burst_left = 0;
  alloc_scoreboard             sb;

  bitmap_block_allocator #(.WORDS(WORDS)) u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .block_index   (block_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .granted_index (granted_index),
    .status        (status)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // sender pacing: bursts of back-to-back beats, random gaps between bursts
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send_item(input logic op, input logic [bba_pkg::INDEX_W-1:0] idx);
    pace();
    in_valid    <= 1'b1;
    opcode      <= op;
    block_index <= idx;
    do @(posedge clk); while (!in_ready);
    sb.note_request(op, idx);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected.size() != 0);
  endtask

  // mostly a block that is currently held, sometimes any index
  function automatic logic [bba_pkg::INDEX_W-1:0] free_target();
    if (sb.taken.size() != 0 && $urandom_range(0, 4) != 0)
      return bba_pkg::INDEX_W'(sb.taken[$urandom_range(0, sb.taken.size() - 1)]);
    return bba_pkg::INDEX_W'($urandom_range(0, 1023));
  endfunction

  // result side: stall pattern switches between modes after runs of random length
  initial begin
    int mode;
    int run;
    mode = 0;
    run = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_result(granted_index, status);
      if (run == 0) begin
        mode = $urandom_range(0, 3);
        run = $urandom_range(20, 300);
      end
      run--;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 9) < 7);
        2: out_ready <= (cycle_count % 4 == 0);
        default: out_ready <= ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed
    send_item(bba_pkg::OP_ALLOC, '0);
    send_item(bba_pkg::OP_ALLOC, '1);
    send_item(bba_pkg::OP_ALLOC, 10'd555);
    send_item(bba_pkg::OP_FREE, 10'd1);
    send_item(bba_pkg::OP_ALLOC, 10'd0);
    send_item(bba_pkg::OP_FREE, 10'd2);
    send_item(bba_pkg::OP_FREE, 10'd2);
    send_item(bba_pkg::OP_FREE, 10'd1023);
    send_item(bba_pkg::OP_FREE, 10'd0);
    send_item(bba_pkg::OP_ALLOC, 10'd1023);
    send_item(bba_pkg::OP_FREE, 10'd64);
    send_item(bba_pkg::OP_FREE, 10'd511);
    send_item(bba_pkg::OP_FREE, 10'd0);
    send_item(bba_pkg::OP_FREE, 10'd1);
    send_item(bba_pkg::OP_FREE, 10'd2);
    wait_drain();

    // fill the map to exhaustion
    while (sb.alloc_fails < 3) begin
      send_item(bba_pkg::OP_ALLOC, bba_pkg::INDEX_W'($urandom));
    end
    wait_drain();

    // drain back down, frees dominate
    repeat (25) begin
      if ($urandom_range(0, 99) < 30) send_item(bba_pkg::OP_ALLOC, bba_pkg::INDEX_W'($urandom));
      else send_item(bba_pkg::OP_FREE, free_target());
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (sb.expected.size() != 0);
    repeat (30) @(posedge clk);
    if (sb.errors == 0 && sb.expected.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
